// ----- hdl/rcc_pkg.sv -----
package rcc_pkg;

  localparam int unsigned COEF_FRAC_BITS_DEF = 16;
  localparam int unsigned PIX_W = 8;
  localparam int unsigned OP_W = PIX_W + 1;
  localparam int unsigned NUM_CH = 3;
  localparam int unsigned PIPE_DEPTH = 4;

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_REV = 1'b1;

  typedef logic signed [OP_W-1:0] op_t;

  // Rounded coefficient magnitude: round-half-up of th / 1000 scaled by 2^frac.
  function automatic longint coef_q(input longint th, input int frac);
    coef_q = ((th << frac) + 64'sd500) / 64'sd1000;
  endfunction

  // Signed coefficient of operand col in output row for one direction.
  function automatic longint coef_val(input int row, input int col, input logic dir,
                                      input int frac);
    longint v;
    v = 0;
    if (dir == DIR_FWD) begin
      case (row * 3 + col)
        0: v = coef_q(299, frac);
        1: v = coef_q(587, frac);
        2: v = coef_q(114, frac);
        3: v = -coef_q(169, frac);
        4: v = -coef_q(331, frac);
        5: v = coef_q(500, frac);
        6: v = coef_q(500, frac);
        7: v = -coef_q(419, frac);
        8: v = -coef_q(81, frac);
        default: v = 0;
      endcase
    end else begin
      case (row * 3 + col)
        0: v = longint'(1) << frac;
        1: v = 0;
        2: v = coef_q(1400, frac);
        3: v = longint'(1) << frac;
        4: v = -coef_q(343, frac);
        5: v = -coef_q(711, frac);
        6: v = longint'(1) << frac;
        7: v = coef_q(1762, frac);
        8: v = 0;
        default: v = 0;
      endcase
    end
    coef_val = v;
  endfunction

  // Constant offset of an output row: 128 for the chroma rows in forward mode.
  function automatic longint base_val(input int row, input logic dir, input int frac);
    base_val = (dir == DIR_FWD && row != 0) ? (longint'(128) << frac) : 0;
  endfunction

endpackage

// ----- hdl/rgb_ycbcr_color_converter_core.sv -----
// Channel        Ports                                                  Handshake
// input word     in_red_or_luma_i, in_green_or_blue_diff_i,             start_i && !busy_o
//                in_blue_or_red_diff_i
// result word    out_luma_or_red_o, out_blue_diff_or_green_o,           done_o, one cycle
//                out_red_diff_or_blue_o
// config         cfg_wdata_i (direction)                                cfg_we_i
//
// A word may be started in every cycle; busy_o is always low.
// Each accepted word passes through the operand register, multiplier register,
// adder register and saturation register before its result appears.
// Reset clears the valid pipeline and sets the direction to RGB to YCbCr.
// The receiver cannot stall, so the pipeline never holds.
module rgb_ycbcr_color_converter_core #(
  parameter int unsigned COEF_FRAC_BITS = rcc_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [rcc_pkg::PIX_W-1:0]  in_red_or_luma_i,
  input  logic [rcc_pkg::PIX_W-1:0]  in_green_or_blue_diff_i,
  input  logic [rcc_pkg::PIX_W-1:0]  in_blue_or_red_diff_i,
  output logic                       done_o,
  output logic [rcc_pkg::PIX_W-1:0]  out_luma_or_red_o,
  output logic [rcc_pkg::PIX_W-1:0]  out_blue_diff_or_green_o,
  output logic [rcc_pkg::PIX_W-1:0]  out_red_diff_or_blue_o
);

  localparam int unsigned LAT = rcc_pkg::PIPE_DEPTH;
  localparam logic [rcc_pkg::OP_W-1:0] Mid = rcc_pkg::OP_W'(2**(rcc_pkg::PIX_W - 1));

  logic               dir_d, dir_q;
  logic               dir_s1_q;
  logic [LAT-1:0]     vld_d, vld_q;
  logic               accept;
  rcc_pkg::op_t       op_d [rcc_pkg::NUM_CH];
  rcc_pkg::op_t       op_q [rcc_pkg::NUM_CH];
  logic [rcc_pkg::PIX_W-1:0] res [rcc_pkg::NUM_CH];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    dir_d = cfg_we_i ? cfg_wdata_i : dir_q;
    vld_d = {vld_q[LAT-2:0], accept};
  end

  always_comb begin
    op_d[0] = rcc_pkg::op_t'({1'b0, in_red_or_luma_i});
    op_d[1] = rcc_pkg::op_t'({1'b0, in_green_or_blue_diff_i});
    op_d[2] = rcc_pkg::op_t'({1'b0, in_blue_or_red_diff_i});
    if (dir_q == rcc_pkg::DIR_REV) begin
      op_d[1] = rcc_pkg::op_t'({1'b0, in_green_or_blue_diff_i} - Mid);
      op_d[2] = rcc_pkg::op_t'({1'b0, in_blue_or_red_diff_i} - Mid);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= rcc_pkg::DIR_FWD;
      vld_q <= '0;
    end else begin
      dir_q <= dir_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    dir_s1_q <= dir_q;
  end

  for (genvar r = 0; r < rcc_pkg::NUM_CH; r++) begin : g_row
    rcc_row #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS),
      .ROW(r)
    ) u_row (
      .clk_i    (clk_i),
      .op_i     (op_q),
      .dir_i    (dir_s1_q),
      .result_o (res[r])
    );
  end

  assign done_o                   = vld_q[LAT-1];
  assign out_luma_or_red_o        = res[0];
  assign out_blue_diff_or_green_o = res[1];
  assign out_red_diff_or_blue_o   = res[2];

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("Result strobe without a word started four cycles earlier.");

  a_rev_neutral_chroma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(dir_q, LAT) == rcc_pkg::DIR_REV
     && $past(in_green_or_blue_diff_i, LAT) == 8'd128
     && $past(in_blue_or_red_diff_i, LAT) == 8'd128)
    |-> (out_luma_or_red_o == $past(in_red_or_luma_i, LAT)
         && out_blue_diff_or_green_o == $past(in_red_or_luma_i, LAT)
         && out_red_diff_or_blue_o == $past(in_red_or_luma_i, LAT)))
    else $error("Neutral chroma did not give gray output.");

  a_fwd_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(dir_q, LAT) == rcc_pkg::DIR_FWD
     && $past(in_red_or_luma_i, LAT) == 8'd0
     && $past(in_green_or_blue_diff_i, LAT) == 8'd0
     && $past(in_blue_or_red_diff_i, LAT) == 8'd0)
    |-> (out_luma_or_red_o == 8'd0 && out_blue_diff_or_green_o == 8'd128
         && out_red_diff_or_blue_o == 8'd128))
    else $error("Black input did not give zero luma and neutral chroma.");

endmodule

// ----- hdl/rcc_row.sv -----
module rcc_row #(
  parameter int unsigned COEF_FRAC_BITS = rcc_pkg::COEF_FRAC_BITS_DEF,
  parameter int unsigned ROW = 0
) (
  input  logic                        clk_i,
  input  rcc_pkg::op_t                op_i [rcc_pkg::NUM_CH],
  input  logic                        dir_i,
  output logic [rcc_pkg::PIX_W-1:0]   result_o
);

  localparam int unsigned CW = COEF_FRAC_BITS + 2;
  localparam int unsigned PW = CW + rcc_pkg::OP_W;
  localparam int unsigned AW = PW + 1;
  localparam int unsigned WW = AW - 1 - COEF_FRAC_BITS;

  localparam logic signed [CW-1:0] FwdC0 = CW'(rcc_pkg::coef_val(ROW, 0, rcc_pkg::DIR_FWD,
                                                                 COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] FwdC1 = CW'(rcc_pkg::coef_val(ROW, 1, rcc_pkg::DIR_FWD,
                                                                 COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] FwdC2 = CW'(rcc_pkg::coef_val(ROW, 2, rcc_pkg::DIR_FWD,
                                                                 COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] RevC0 = CW'(rcc_pkg::coef_val(ROW, 0, rcc_pkg::DIR_REV,
                                                                 COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] RevC1 = CW'(rcc_pkg::coef_val(ROW, 1, rcc_pkg::DIR_REV,
                                                                 COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] RevC2 = CW'(rcc_pkg::coef_val(ROW, 2, rcc_pkg::DIR_REV,
                                                                 COEF_FRAC_BITS));
  localparam logic signed [AW-1:0] FwdBase = AW'(rcc_pkg::base_val(ROW, rcc_pkg::DIR_FWD,
                                                                   COEF_FRAC_BITS));
  localparam logic signed [AW-1:0] RevBase = AW'(rcc_pkg::base_val(ROW, rcc_pkg::DIR_REV,
                                                                   COEF_FRAC_BITS));

  logic signed [CW-1:0] coef_sel [rcc_pkg::NUM_CH];
  logic signed [PW-1:0] prod_d [rcc_pkg::NUM_CH];
  logic signed [PW-1:0] prod_q [rcc_pkg::NUM_CH];
  logic                 dir_s2_q;
  logic signed [AW-1:0] sum_d, sum_q;
  logic [WW-1:0]        whole;
  logic [rcc_pkg::PIX_W-1:0] result_d, result_q;

  always_comb begin
    coef_sel[0] = (dir_i == rcc_pkg::DIR_REV) ? RevC0 : FwdC0;
    coef_sel[1] = (dir_i == rcc_pkg::DIR_REV) ? RevC1 : FwdC1;
    coef_sel[2] = (dir_i == rcc_pkg::DIR_REV) ? RevC2 : FwdC2;
    for (int k = 0; k < rcc_pkg::NUM_CH; k++) begin
      prod_d[k] = PW'(op_i[k]) * PW'(coef_sel[k]);
    end
  end

  always_comb begin
    sum_d = ((dir_s2_q == rcc_pkg::DIR_REV) ? RevBase : FwdBase)
            + AW'(prod_q[0]) + AW'(prod_q[1]) + AW'(prod_q[2]);
  end

  always_comb begin
    whole = sum_q[AW-2:COEF_FRAC_BITS];
    if (sum_q[AW-1]) begin
      result_d = '0;
    end else if (whole > WW'(2**rcc_pkg::PIX_W - 1)) begin
      result_d = '1;
    end else begin
      result_d = whole[rcc_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    dir_s2_q <= dir_i;
    sum_q    <= sum_d;
    result_q <= result_d;
  end

  assign result_o = result_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAC = rcc_pkg::COEF_FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_PIXELS = 80;

  typedef struct packed {
    logic [rcc_pkg::PIX_W-1:0] luma_or_red;
    logic [rcc_pkg::PIX_W-1:0] blue_diff_or_green;
    logic [rcc_pkg::PIX_W-1:0] red_diff_or_blue;
  } color_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic                      cfg_wdata_i;
  logic                      start_i;
  logic                      busy_o;
  logic [rcc_pkg::PIX_W-1:0] in_red_or_luma_i;
  logic [rcc_pkg::PIX_W-1:0] in_green_or_blue_diff_i;
  logic [rcc_pkg::PIX_W-1:0] in_blue_or_red_diff_i;
  logic                      done_o;
  logic [rcc_pkg::PIX_W-1:0] out_luma_or_red_o;
  logic [rcc_pkg::PIX_W-1:0] out_blue_diff_or_green_o;
  logic [rcc_pkg::PIX_W-1:0] out_red_diff_or_blue_o;

  logic   direction_model;
  color_t pending_colors[$];
  int     mismatches;
  int     cycles;

  rgb_ycbcr_color_converter_core dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_we_i                 (cfg_we_i),
    .cfg_wdata_i              (cfg_wdata_i),
    .start_i                  (start_i),
    .busy_o                   (busy_o),
    .in_red_or_luma_i         (in_red_or_luma_i),
    .in_green_or_blue_diff_i  (in_green_or_blue_diff_i),
    .in_blue_or_red_diff_i    (in_blue_or_red_diff_i),
    .done_o                   (done_o),
    .out_luma_or_red_o        (out_luma_or_red_o),
    .out_blue_diff_or_green_o (out_blue_diff_or_green_o),
    .out_red_diff_or_blue_o   (out_red_diff_or_blue_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic longint fixed_coef(input longint thousandths);
    return ((thousandths << FRAC) + 500) / 1000;
  endfunction

  // The arithmetic shift floors toward minus infinity before clamping.
  function automatic logic [rcc_pkg::PIX_W-1:0] floor_clamp(input longint acc);
    longint whole;
    whole = acc >>> FRAC;
    if (whole < 0) return '0;
    if (whole > 255) return 8'hFF;
    return whole[rcc_pkg::PIX_W-1:0];
  endfunction

  function automatic color_t convert_pixel(input logic dir,
                                           input logic [rcc_pkg::PIX_W-1:0] x0,
                                           input logic [rcc_pkg::PIX_W-1:0] x1,
                                           input logic [rcc_pkg::PIX_W-1:0] x2);
    longint a;
    longint b;
    longint c;
    longint half;
    color_t res;
    a = x0;
    b = x1;
    c = x2;
    half = longint'(128) << FRAC;
    if (dir == rcc_pkg::DIR_FWD) begin
      res.luma_or_red = floor_clamp(fixed_coef(299) * a + fixed_coef(587) * b
                                    + fixed_coef(114) * c);
      res.blue_diff_or_green = floor_clamp(half - fixed_coef(169) * a
                                           - fixed_coef(331) * b + fixed_coef(500) * c);
      res.red_diff_or_blue = floor_clamp(half + fixed_coef(500) * a
                                         - fixed_coef(419) * b - fixed_coef(81) * c);
    end else begin
      a = a << FRAC;
      b = b - 128;
      c = c - 128;
      res.luma_or_red = floor_clamp(a + fixed_coef(1400) * c);
      res.blue_diff_or_green = floor_clamp(a - fixed_coef(343) * b - fixed_coef(711) * c);
      res.red_diff_or_blue = floor_clamp(a + fixed_coef(1762) * b);
    end
    return res;
  endfunction

  function automatic logic [rcc_pkg::PIX_W-1:0] pick_level();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return rcc_pkg::PIX_W'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_pixel(input logic [rcc_pkg::PIX_W-1:0] x0,
                            input logic [rcc_pkg::PIX_W-1:0] x1,
                            input logic [rcc_pkg::PIX_W-1:0] x2);
    @(negedge clk_i);
    start_i <= 1'b1;
    in_red_or_luma_i <= x0;
    in_green_or_blue_diff_i <= x1;
    in_blue_or_red_diff_i <= x2;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_colors.push_back(convert_pixel(direction_model, x0, x1, x2));
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      in_red_or_luma_i <= pick_level();
      in_green_or_blue_diff_i <= pick_level();
      in_blue_or_red_diff_i <= pick_level();
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (rcc_pkg::PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  task automatic set_direction(input logic dir);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= dir;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    direction_model = dir;
  endtask

  task automatic test_forward_extremes();
    logic [3*rcc_pkg::PIX_W-1:0] pixels[11];
    pixels = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h00FFFF,
               24'hFF00FF, 24'hFFFF00, 24'h808080, 24'h010101, 24'hFEFEFE};
    set_direction(rcc_pkg::DIR_FWD);
    foreach (pixels[i]) send_pixel(pixels[i][23:16], pixels[i][15:8], pixels[i][7:0]);
  endtask

  // Covers clamping at both ends of every reverse channel.
  task automatic test_reverse_extremes();
    logic [3*rcc_pkg::PIX_W-1:0] pixels[11];
    pixels = '{24'h000000, 24'hFFFFFF, 24'h00FFFF, 24'hFF0000, 24'h808080, 24'h008080,
               24'hFF8080, 24'h108080, 24'hEBF010, 24'h6400FF, 24'h64FF00};
    set_direction(rcc_pkg::DIR_REV);
    foreach (pixels[i]) send_pixel(pixels[i][23:16], pixels[i][15:8], pixels[i][7:0]);
  endtask

  task automatic test_random_stream();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_direction((ph % 2 == 0) ? rcc_pkg::DIR_FWD : rcc_pkg::DIR_REV);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        if (ph == 2 && i == PHASE_PIXELS / 2) drain();
        if (ph < RANDOM_PHASES - 1 && $urandom_range(0, 3) == 0)
          idle_cycles($urandom_range(1, 16));
        send_pixel(pick_level(), pick_level(), pick_level());
      end
    end
  endtask

  task automatic finish_run();
    drain();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  endtask

  always @(posedge clk_i) begin : result_check
    color_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_colors.size() == 0) begin
        report_mismatch("word with none pending, first channel", out_luma_or_red_o, -1);
      end else begin
        want = pending_colors.pop_front();
        if (out_luma_or_red_o !== want.luma_or_red)
          report_mismatch("Y/R", out_luma_or_red_o, want.luma_or_red);
        if (out_blue_diff_or_green_o !== want.blue_diff_or_green)
          report_mismatch("Cb/G", out_blue_diff_or_green_o, want.blue_diff_or_green);
        if (out_red_diff_or_blue_o !== want.red_diff_or_blue)
          report_mismatch("Cr/B", out_red_diff_or_blue_o, want.red_diff_or_blue);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    direction_model = rcc_pkg::DIR_FWD;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    start_i = 1'b0;
    in_red_or_luma_i = '0;
    in_green_or_blue_diff_i = '0;
    in_blue_or_red_diff_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_forward_extremes();
    test_reverse_extremes();
    test_random_stream();
    finish_run();
  end

endmodule
